// ----- design/spq_pkg.sv -----
package spq_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_PEEK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic        [1:0]  func;
        logic signed [31:0] item_value;
        logic signed [15:0] item_priority;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] head_value;
        logic        [1:0]  status;
        logic        [4:0]  occupancy;
    } out_word_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

// ----- design/spq_cell.sv -----
module spq_cell (
    input  logic              aclk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic              occupied,
    input  spq_pkg::entry_t   new_entry,
    input  spq_pkg::entry_t   left_entry,
    input  logic              left_keep,
    input  spq_pkg::entry_t   right_entry,
    output spq_pkg::entry_t   entry,
    output logic              keep
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // entry stays put when it sorts at or ahead of the new one
    assign keep  = occupied && (entry_reg.prio <= new_entry.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.insert && !keep) begin
            entry_next = left_keep ? new_entry : left_entry;
        end else if (ctrl.remove) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ----- design/stable_priority_queue_top.sv -----
// Sorted priority queue of QUEUE_DEPTH entries held in a row of cells, head in
// cell 0; lower priority numbers leave first and equal priorities leave in
// arrival order. Each word is an insert, remove, peek or no-op and yields exactly
// one result word in the cycle after it is accepted; all cells compare against
// the incoming priority and shift together, so a new word can be taken every
// cycle while the result side keeps up. Remove or peek on an empty queue
// reports empty and leaves the queue as is; an insert into a full queue is
// dropped and reported full. Occupancy carries the low 5 bits of the count.
module stable_priority_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  spq_pkg::in_word_t s_word,
    output logic              m_valid,
    input  logic              m_ready,
    output spq_pkg::out_word_t m_word
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    spq_pkg::out_word_t    m_word_reg;
    spq_pkg::out_word_t    m_word_next;

    logic                  accept;
    logic                  is_empty;
    logic                  is_full;
    spq_pkg::cell_ctrl_t   ctrl;
    spq_pkg::entry_t       new_entry;
    spq_pkg::entry_t       cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_keep;
    logic [QUEUE_DEPTH-1:0] occupied;
    logic [CW+4:0]         occ_ext;
    logic signed [31:0]    head_value;
    logic [1:0]            status;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg >= CW'(QUEUE_DEPTH));

    assign new_entry.value = s_word.item_value;
    assign new_entry.prio  = s_word.item_priority;

    always_comb begin
        ctrl       = '0;
        count_next = count_reg;
        head_value = '0;
        status     = spq_pkg::ST_OK;
        unique case (s_word.func)
            spq_pkg::FUNC_INSERT: begin
                if (is_full) begin
                    status = spq_pkg::ST_FULL;
                end else begin
                    ctrl.insert = accept;
                    count_next  = count_reg + CW'(1);
                end
            end
            spq_pkg::FUNC_REMOVE: begin
                if (is_empty) begin
                    status = spq_pkg::ST_EMPTY;
                end else begin
                    ctrl.remove = accept;
                    head_value  = cell_entry[0].value;
                    count_next  = count_reg - CW'(1);
                end
            end
            spq_pkg::FUNC_PEEK: begin
                if (is_empty) begin
                    status = spq_pkg::ST_EMPTY;
                end else begin
                    head_value = cell_entry[0].value;
                end
            end
            default: begin
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            spq_pkg::entry_t left_entry;
            spq_pkg::entry_t right_entry;
            logic            left_keep;

            assign occupied[i] = (CW'(i) < count_reg);

            if (i == 0) begin : g_head
                assign left_entry = new_entry;
                assign left_keep  = 1'b1;
            end else begin : g_body
                assign left_entry = cell_entry[i-1];
                assign left_keep  = cell_keep[i-1];
            end

            if (i == QUEUE_DEPTH - 1) begin : g_tail
                assign right_entry = new_entry;
            end else begin : g_inner
                assign right_entry = cell_entry[i+1];
            end

            spq_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .occupied    (occupied[i]),
                .new_entry   (new_entry),
                .left_entry  (left_entry),
                .left_keep   (left_keep),
                .right_entry (right_entry),
                .entry       (cell_entry[i]),
                .keep        (cell_keep[i])
            );
        end
    endgenerate

    assign occ_ext = {5'b0, count_next};

    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next           = 1'b1;
            m_word_next.head_value = head_value;
            m_word_next.status     = status;
            m_word_next.occupancy  = occ_ext[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// ----- test/spq_checker.sv -----
`timescale 1ns / 1ps
module spq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  spq_pkg::in_word_t  s_word,
    input  logic               m_valid,
    input  logic               m_ready,
    input  spq_pkg::out_word_t m_word,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count,
    output int                 full_count,
    output int                 empty_count
);

    logic signed [31:0] held_values [QUEUE_DEPTH];
    logic signed [15:0] held_ranks  [QUEUE_DEPTH];
    int                 held_count;
    spq_pkg::out_word_t awaited_results [$];

    function automatic spq_pkg::out_word_t next_queue_result(spq_pkg::in_word_t w);
        spq_pkg::out_word_t r;
        int        pos;
        int        i;
        r = '0;
        r.status = spq_pkg::ST_OK;
        case (w.func)
            spq_pkg::FUNC_INSERT: begin
                if (held_count >= QUEUE_DEPTH) begin
                    r.status = spq_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < held_count &&
                           $signed(held_ranks[pos]) <= $signed(w.item_priority))
                        pos++;
                    for (i = held_count; i > pos; i--) begin
                        held_values[i] = held_values[i - 1];
                        held_ranks[i]  = held_ranks[i - 1];
                    end
                    held_values[pos] = w.item_value;
                    held_ranks[pos]  = w.item_priority;
                    held_count++;
                end
            end
            spq_pkg::FUNC_REMOVE, spq_pkg::FUNC_PEEK: begin
                if (held_count == 0) begin
                    r.status = spq_pkg::ST_EMPTY;
                end else begin
                    r.head_value = held_values[0];
                    if (w.func == spq_pkg::FUNC_REMOVE) begin
                        for (i = 0; i + 1 < held_count; i++) begin
                            held_values[i] = held_values[i + 1];
                            held_ranks[i]  = held_ranks[i + 1];
                        end
                        held_count--;
                    end
                end
            end
            default: begin
            end
        endcase
        r.occupancy = held_count[4:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        spq_pkg::out_word_t want;
        logic      bad;
        if (!aresetn) begin
            held_count = 0;
            awaited_results.delete();
            fail_count   <= 0;
            pending      <= 0;
            result_count <= 0;
            full_count   <= 0;
            empty_count  <= 0;
        end else begin
            if (s_valid && s_ready)
                awaited_results.push_back(next_queue_result(s_word));
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result word: head_value %0d status %0d occupancy %0d",
                           m_word.head_value, m_word.status, m_word.occupancy);
                    fail_count <= fail_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    bad  = 1'b0;
                    if (m_word.head_value !== want.head_value) begin
                        $error("head_value: expected %0d, got %0d",
                               want.head_value, m_word.head_value);
                        bad = 1'b1;
                    end
                    if (m_word.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_word.status);
                        bad = 1'b1;
                    end
                    if (m_word.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, m_word.occupancy);
                        bad = 1'b1;
                    end
                    if (bad)
                        fail_count <= fail_count + 1;
                    result_count <= result_count + 1;
                    if (want.status == spq_pkg::ST_FULL)
                        full_count <= full_count + 1;
                    if (want.status == spq_pkg::ST_EMPTY)
                        empty_count <= empty_count + 1;
                end
            end
            pending <= awaited_results.size();
        end
    end

endmodule

// ----- test/stable_priority_queue_top_tb.sv -----
`timescale 1ns / 1ps
module stable_priority_queue_top_tb;

    localparam int DEPTH      = 16;
    localparam int RAND_WORDS = 1240;
    localparam int HOLD_OFF   = 80;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    spq_pkg::in_word_t  s_word  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    spq_pkg::out_word_t m_word;

    int fail_count;
    int pending;
    int result_count;
    int full_count;
    int empty_count;

    int hold_ask   = 0;
    int burst_left = 0;
    int words_sent = 0;

    stable_priority_queue_top #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_word (s_word),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_word (m_word)
    );

    spq_checker #(
        .QUEUE_DEPTH(DEPTH)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word),
        .fail_count  (fail_count),
        .pending     (pending),
        .result_count(result_count),
        .full_count  (full_count),
        .empty_count (empty_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: shifting stall patterns plus one long hold-off on request
    initial begin
        int       cyc;
        int       hold_seen;
        rx_mode_t mode;
        cyc       = 0;
        hold_seen = 0;
        mode      = RX_OPEN;
        forever begin
            @(posedge aclk);
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
            end
            if (cyc % 150 == 0)
                mode = rx_mode_t'($urandom_range(0, 3));
            cyc++;
            case (mode)
                RX_OPEN:     m_ready <= 1'b1;
                RX_COIN:     m_ready <= $urandom_range(0, 1);
                RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: m_ready <= (cyc % 3 != 0);
                default:     m_ready <= 1'b1;
            endcase
        end
    end

    task automatic send_word(input spq_pkg::in_word_t w);
        s_word  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_paced(input spq_pkg::in_word_t w);
        send_word(w);
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic spq_pkg::in_word_t make_word(logic [1:0] f, logic [31:0] v,
                                                    logic [15:0] r);
        spq_pkg::in_word_t w;
        w.func          = f;
        w.item_value    = v;
        w.item_priority = r;
        return w;
    endfunction

    function automatic logic [15:0] pick_rank();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 16'($signed($urandom_range(0, 6)) - 3);
        if (sel < 85)
            return 16'($urandom());
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            default: return 16'h0000;
        endcase
    endfunction

    initial begin
        logic [15:0] tie_ranks [14];
        logic [1:0]  f;
        int          insert_weight;
        int          seg_left;
        int          real_words;
        int          sel;

        tie_ranks = '{16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'h7fff, 16'h8000, 16'h0005,
                      16'h0005, 16'h0000, 16'hffff, 16'h0003, 16'h0003, 16'h0000, 16'h8000};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_left = $urandom_range(1, 10);

        // empty queue, no-op code, value and priority extremes
        send_paced(make_word(spq_pkg::FUNC_PEEK, 32'h1234_5678, 16'h1111));
        send_paced(make_word(spq_pkg::FUNC_REMOVE, 32'hffff_ffff, 16'hffff));
        send_paced(make_word(2'd3, 32'hffff_ffff, 16'hffff));
        send_paced(make_word(spq_pkg::FUNC_INSERT, 32'h8000_0000, 16'h7fff));
        send_paced(make_word(spq_pkg::FUNC_INSERT, 32'h7fff_ffff, 16'h8000));
        send_paced(make_word(spq_pkg::FUNC_PEEK, 32'h0, 16'h0));
        // fill with ties, then overflow
        for (int i = 0; i < 14; i++)
            send_paced(make_word(spq_pkg::FUNC_INSERT, 32'(i + 1), tie_ranks[i]));
        send_paced(make_word(spq_pkg::FUNC_INSERT, 32'hdead_beef, 16'h8000));
        send_paced(make_word(spq_pkg::FUNC_PEEK, 32'h0, 16'h0));
        send_paced(make_word(spq_pkg::FUNC_REMOVE, 32'h0, 16'h0));
        send_paced(make_word(2'd3, 32'h0, 16'h0));
        send_paced(make_word(spq_pkg::FUNC_INSERT, 32'h5555_aaaa, 16'h0000));

        // long receiver hold-off while words keep coming back to back
        hold_ask <= hold_ask + 1;
        for (int i = 0; i < 40; i++)
            send_word(make_word(($urandom_range(0, 3) == 0) ? spq_pkg::FUNC_REMOVE
                                                            : spq_pkg::FUNC_INSERT,
                                $urandom(), pick_rank()));

        real_words    = 0;
        seg_left      = 0;
        insert_weight = 50;
        while (real_words < RAND_WORDS) begin
            if (seg_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_weight = 85;
                    1:       insert_weight = 50;
                    default: insert_weight = 20;
                endcase
                seg_left = $urandom_range(30, 60);
            end
            seg_left--;
            sel = $urandom_range(0, 99);
            if (sel < insert_weight)
                f = spq_pkg::FUNC_INSERT;
            else if (sel < 96)
                f = ($urandom_range(0, 3) == 0) ? spq_pkg::FUNC_PEEK : spq_pkg::FUNC_REMOVE;
            else
                f = 2'd3;
            send_paced(make_word(f, $urandom(), pick_rank()));
            if (f != 2'd3)
                real_words++;
            if (real_words == RAND_WORDS / 2 && f != 2'd3)
                wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("sent %0d words, checked %0d results: %0d inserts dropped full, %0d empty reads",
                 words_sent, result_count, full_count, empty_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
